// File: sv/gtb_pkg.sv
`default_nettype none

package gtb_pkg;

  // bank size and clocking constants
  localparam int unsigned NUM_TIMERS  = 4;
  localparam int unsigned HOLD_TIMERS = 2;
  localparam int unsigned HBLANK_STEP = 1;
  localparam int unsigned IRQ_BITS    = 4;

  // mode register bit positions
  localparam int unsigned MB_GATE_EN  = 2;
  localparam int unsigned MB_GATE_SRC = 3;
  localparam int unsigned MB_GM_LO    = 4;
  localparam int unsigned MB_ZRET     = 6;
  localparam int unsigned MB_RUN      = 7;
  localparam int unsigned MB_TINT     = 8;
  localparam int unsigned MB_OINT     = 9;
  localparam int unsigned MB_TFLAG    = 10;
  localparam int unsigned MB_OFLAG    = 11;

  localparam logic [11:0] MODE_FLAGS = 12'hc00;
  localparam logic [11:0] MODE_LOW   = 12'h3ff;

  // prescaler rates
  localparam logic [9:0] RATE_BUS2   = 10'd2;
  localparam logic [9:0] RATE_BUS32  = 10'd32;
  localparam logic [9:0] RATE_BUS512 = 10'd512;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_HSTART   = 3'd1,
    OP_HEND     = 3'd2,
    OP_VSTART   = 3'd3,
    OP_VEND     = 3'd4,
    OP_WRITE    = 3'd5,
    OP_READ     = 3'd6
  } gtb_op_e;

  typedef enum logic [1:0] {
    REG_COUNT  = 2'd0,
    REG_MODE   = 2'd1,
    REG_TARGET = 2'd2,
    REG_HOLD   = 2'd3
  } gtb_reg_e;

  typedef enum logic [1:0] {
    CLK_BUS2   = 2'd0,
    CLK_BUS32  = 2'd1,
    CLK_BUS512 = 2'd2,
    CLK_HBLANK = 2'd3
  } gtb_clk_e;

  typedef enum logic [1:0] {
    GM_RUN_IN_BLANK = 2'd0,
    GM_RST_AT_START = 2'd1,
    GM_RST_AT_END   = 2'd2,
    GM_RST_AT_BOTH  = 2'd3
  } gtb_gate_e;

  // command broadcast to every timer channel
  typedef struct packed {
    logic        en;
    logic [2:0]  op;
    logic [1:0]  reg_sel;
    logic [15:0] write_data;
  } gtb_cmd_t;

  // what one channel hands back
  typedef struct packed {
    logic        irq;
    logic [15:0] rd_data;
  } gtb_chan_t;

endpackage

`default_nettype wire

// File: sv/gtb_timer.sv
`default_nettype none

module gtb_timer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gtb_pkg::gtb_cmd_t cmd_i,
  input  wire logic              sel_hit_i,
  output gtb_pkg::gtb_chan_t     chan_o
);
  import gtb_pkg::*;

  logic [15:0] count_q, count_d;
  logic [15:0] target_q, target_d;
  logic        armed_q, armed_d;
  logic [11:0] mode_q, mode_d;
  logic [8:0]  presc_q, presc_d;
  logic        gate_q, gate_d;

  logic [16:0] c;
  logic [9:0]  p;
  logic [9:0]  rate;
  logic        chk;
  logic        irq;
  logic [15:0] rd;
  logic        is_edge;
  logic        is_start;
  logic        is_vblank;
  logic [11:0] m_new;
  gtb_op_e     op;
  gtb_reg_e    rsel;
  gtb_gate_e   gm;
  gtb_clk_e    cs;

  always_comb begin
    op        = gtb_op_e'(cmd_i.op);
    rsel      = gtb_reg_e'(cmd_i.reg_sel);
    count_d   = count_q;
    target_d  = target_q;
    armed_d   = armed_q;
    mode_d    = mode_q;
    presc_d   = presc_q;
    gate_d    = gate_q;
    c         = {1'b0, count_q};
    p         = {1'b0, presc_q} + 10'd1;
    chk       = 1'b0;
    irq       = 1'b0;
    rd        = '0;
    is_edge   = 1'b0;
    is_start  = 1'b0;
    is_vblank = 1'b0;
    m_new     = '0;
    cs        = gtb_clk_e'(mode_q[1:0]);

    case (cs)
      CLK_BUS2:  rate = RATE_BUS2;
      CLK_BUS32: rate = RATE_BUS32;
      default:   rate = RATE_BUS512;
    endcase

    case (op)
      OP_TICK: begin
        if (mode_q[MB_RUN] && cs != CLK_HBLANK) begin
          chk = 1'b1;
          if (p >= rate) begin
            p = '0;
            c = {1'b0, count_q} + 17'd1;
          end
          presc_d = p[8:0];
        end
      end
      OP_HSTART: begin
        is_edge  = 1'b1;
        is_start = 1'b1;
        if (mode_q[MB_RUN] && cs == CLK_HBLANK) begin
          chk = 1'b1;
          c   = {1'b0, count_q} + 17'(HBLANK_STEP);
        end
      end
      OP_HEND: begin
        is_edge = 1'b1;
      end
      OP_VSTART: begin
        is_edge   = 1'b1;
        is_start  = 1'b1;
        is_vblank = 1'b1;
      end
      OP_VEND: begin
        is_edge   = 1'b1;
        is_vblank = 1'b1;
      end
      default: begin
      end
    endcase

    // target test, then overflow test
    if (chk) begin
      if (armed_q && c >= {1'b0, target_q}) begin
        if (mode_q[MB_TINT]) begin
          mode_d[MB_TFLAG] = 1'b1;
          irq = 1'b1;
          if (mode_q[MB_ZRET]) begin
            c = c - {1'b0, target_q};
          end else begin
            armed_d = 1'b0;
          end
        end else begin
          armed_d = 1'b0;
        end
      end
      if (c[16]) begin
        if (mode_q[MB_OINT]) begin
          mode_d[MB_OFLAG] = 1'b1;
          irq = 1'b1;
        end
        armed_d = 1'b1;
      end
      count_d = c[15:0];
    end

    // gate reaction to a blank edge
    gm = gtb_gate_e'(mode_q[MB_GM_LO +: 2]);
    if (cmd_i.en && is_edge && gate_q && (mode_q[MB_GATE_SRC] == is_vblank)) begin
      if (gm == GM_RUN_IN_BLANK) begin
        mode_d[MB_RUN] = is_start;
        presc_d        = '0;
      end else if (gm == GM_RST_AT_BOTH || (is_start && gm == GM_RST_AT_START) ||
                   (!is_start && gm == GM_RST_AT_END)) begin
        mode_d[MB_RUN] = 1'b1;
        count_d        = '0;
        armed_d        = 1'b1;
        presc_d        = '0;
      end
    end

    if (op == OP_WRITE && sel_hit_i) begin
      case (rsel)
        REG_COUNT: begin
          count_d = cmd_i.write_data;
          armed_d = !(cmd_i.write_data > target_q);
          if (!mode_q[MB_RUN]) presc_d = '0;
        end
        REG_MODE: begin
          if (!mode_q[MB_RUN]) presc_d = '0;
          m_new = (mode_q & MODE_FLAGS & ~(cmd_i.write_data[11:0] & MODE_FLAGS)) |
                  (cmd_i.write_data[11:0] & MODE_LOW);
          mode_d = m_new;
          if (m_new[MB_GATE_EN] &&
              !(!m_new[MB_GATE_SRC] && gtb_clk_e'(m_new[1:0]) == CLK_HBLANK)) begin
            gate_d         = 1'b1;
            mode_d[MB_RUN] = 1'b0;
            count_d        = '0;
            presc_d        = '0;
          end else begin
            gate_d = 1'b0;
          end
        end
        REG_TARGET: begin
          target_d = cmd_i.write_data;
          armed_d  = cmd_i.write_data > count_q;
        end
        default: begin
        end
      endcase
    end

    if (op == OP_READ && sel_hit_i) begin
      case (rsel)
        REG_COUNT:  rd = count_q;
        REG_MODE:   rd = {4'b0, mode_q};
        REG_TARGET: rd = target_q;
        default:    rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      target_q <= 16'hffff;
      armed_q  <= 1'b1;
      mode_q   <= '0;
      presc_q  <= '0;
      gate_q   <= 1'b0;
    end else if (cmd_i.en) begin
      count_q  <= count_d;
      target_q <= target_d;
      armed_q  <= armed_d;
      mode_q   <= mode_d;
      presc_q  <= presc_d;
      gate_q   <= gate_d;
    end
  end

  assign chan_o.irq     = irq;
  assign chan_o.rd_data = rd;

endmodule

`default_nettype wire

// File: sv/gated_timer_bank.sv
// gated_timer_bank: four 16-bit timers, each with count, mode and target registers, timers 0
// and 1 with a hold register. Every input transfer is one bus tick, one hblank/vblank edge, one
// register write or one register read, and produces exactly one result transfer carrying read
// data (zero unless the item is a read) and a per-timer interrupt pulse mask (nonzero only on a
// tick or an hblank start). The block takes one item per clock cycle: an item is held in the
// input register, is applied to all timers at once by combinational logic and lands in the
// result register, and the result register parts the two sides.
// Throughput drops below one per cycle only while out_stall_i holds a finished result.
// Timer state resets to count 0, target 0xffff armed, mode 0, gate inactive.

`default_nettype none

module gated_timer_bank (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [1:0]  counter_sel_i,
  input  wire logic [1:0]  reg_sel_i,
  input  wire logic [15:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      read_data_o,
  output logic [3:0]       irq_pulse_o
);
  import gtb_pkg::*;

  // input register
  logic        in_valid_q;
  logic [2:0]  op_q;
  logic [1:0]  sel_q;
  logic [1:0]  reg_q;
  logic [15:0] wdata_q;

  // result register
  logic        out_valid_q;
  logic [15:0] rdata_q, rdata_d;
  logic [IRQ_BITS-1:0] irq_q, irq_d;

  // hold registers, timers 0 and 1 only
  logic [15:0] hold_q [HOLD_TIMERS];

  logic      in_xfer;
  logic      adv;
  gtb_cmd_t  cmd;
  gtb_chan_t chan [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] irq_all;
  logic [15:0] chan_rd;
  logic [15:0] hold_rd;

  // an item moves to the result register whenever the result slot is free or leaving
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= op_i;
      sel_q   <= counter_sel_i;
      reg_q   <= reg_sel_i;
      wdata_q <= write_data_i;
    end
  end

  // command seen by every timer, qualified by the advance strobe
  assign cmd.en         = adv;
  assign cmd.op         = op_q;
  assign cmd.reg_sel    = reg_q;
  assign cmd.write_data = wdata_q;

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    gtb_timer u_timer (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .sel_hit_i (32'(sel_q) == t),
      .chan_o    (chan[t])
    );
    assign irq_all[t] = chan[t].irq;
  end

  // only one channel can answer a read, so an or across them is the mux
  always_comb begin
    chan_rd = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      chan_rd = chan_rd | chan[t].rd_data;
    end
  end

  always_comb begin
    hold_rd = '0;
    for (int h = 0; h < HOLD_TIMERS; h++) begin
      if (32'(sel_q) == h) hold_rd = hold_q[h];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < HOLD_TIMERS; h++) hold_q[h] <= '0;
    end else if (adv && gtb_op_e'(op_q) == OP_WRITE && gtb_reg_e'(reg_q) == REG_HOLD) begin
      for (int h = 0; h < HOLD_TIMERS; h++) begin
        if (32'(sel_q) == h) hold_q[h] <= wdata_q;
      end
    end
  end

  always_comb begin
    rdata_d = chan_rd;
    if (gtb_op_e'(op_q) == OP_READ && gtb_reg_e'(reg_q) == REG_HOLD) begin
      rdata_d = hold_rd;
    end
  end

  // pulse mask carries timers 0 to 3 only
  for (genvar b = 0; b < IRQ_BITS; b++) begin : g_irq
    if (b < NUM_TIMERS) begin : g_live
      assign irq_d[b] = irq_all[b];
    end else begin : g_none
      assign irq_d[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign irq_pulse_o = irq_q;

  // interrupts only come from a tick or an hblank start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && gtb_op_e'(op_q) != OP_TICK && gtb_op_e'(op_q) != OP_HSTART
    |=> irq_pulse_o == '0)
    else $error("irq pulse on an item that cannot interrupt");

  // read data is zero for anything but a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && gtb_op_e'(op_q) != OP_READ |=> read_data_o == '0)
    else $error("read data on a non-read item");

  // a transfer into the result register always leaves a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result lost on advance");

  // the input register is only held back when a result is stuck downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled with the result slot free");

endmodule

`default_nettype wire
